// ----- rtl/mml_pkg.sv -----
package mml_pkg;

    localparam int TIME_BITS_DEF = 32;
    localparam int MAX_TRACK_DEF = 15;
    localparam int MAX_DOTS_DEF  = 7;

    localparam logic [15:0] TPB_RESET = 16'd480;
    localparam int DIV_BITS = 18;
    localparam int DUR_BITS = 19;
    localparam int CNT_BITS = 5;

    localparam logic [7:0] CH_LF  = 8'h0a;
    localparam logic [7:0] CH_CR  = 8'h0d;
    localparam logic [7:0] CH_TAB = 8'h09;

    localparam logic [2:0] OCT_RESET   = 3'd4;
    localparam logic [7:0] LEN_RESET   = 8'd8;
    localparam logic [6:0] VOL_RESET   = 7'd127;
    localparam logic [8:0] TEMPO_RESET = 9'd120;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LEN,
        CMD_OCT,
        CMD_PROG,
        CMD_VOL,
        CMD_TEMPO,
        CMD_NOTE_ACC,
        CMD_NOTE_NUM,
        CMD_NOTE_DOT,
        CMD_REST_NUM,
        CMD_REST_DOT
    } t_cmd;

    typedef enum logic [2:0] {
        EV_NOTE_ON  = 3'd0,
        EV_NOTE_OFF = 3'd1,
        EV_PROG     = 3'd2,
        EV_TEMPO    = 3'd3,
        EV_REST     = 3'd4,
        EV_END      = 3'd5
    } t_event;

    typedef enum logic [1:0] {F_IDLE, F_MAIN, F_EOT, F_END} t_fstate;

    typedef enum logic [2:0] {B_IDLE, B_DIV, B_DOT, B_EMIT, B_EMIT2} t_bstate;

    // quiet: no words out, time still advances
    typedef struct packed {
        t_event      op;
        logic [6:0]  key;
        logic [8:0]  value;
        logic [3:0]  chan;
        logic [15:0] den;
        logic [3:0]  dots;
        logic        err;
        logic        last;
        logic        quiet;
    } t_job;

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= "A" && c <= "Z") r = c + 8'd32;
        return r;
    endfunction

    // {valid, semitone}
    function automatic logic [4:0] semitone(input logic [7:0] lc);
        logic [4:0] r;
        unique case (lc)
            "c":     r = {1'b1, 4'd0};
            "d":     r = {1'b1, 4'd2};
            "e":     r = {1'b1, 4'd4};
            "f":     r = {1'b1, 4'd5};
            "g":     r = {1'b1, 4'd7};
            "a":     r = {1'b1, 4'd9};
            "b":     r = {1'b1, 4'd11};
            default: r = 5'd0;
        endcase
        return r;
    endfunction

    function automatic logic [15:0] clamp_num(input logic [15:0] acc, input logic neg,
                                              input logic [15:0] hi);
        logic [15:0] r;
        if (neg) r = 16'd0;
        else if (acc > hi) r = hi;
        else r = acc;
        return r;
    endfunction

    function automatic logic [15:0] digit_in(input logic [15:0] acc, input logic [7:0] c);
        logic [19:0] v;
        v = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {16'b0, c[3:0]};
        return (v > 20'd65535) ? 16'hffff : v[15:0];
    endfunction

endpackage

// ----- rtl/mml_text_to_note_events.sv -----
// Channel   Handshake                 Word
// text in   i_valid / o_ready         i_char_code, i_end_of_text
// events    o_valid / i_ready         o_event_kind .. o_last_of_run
// config    i_cfg_valid / o_cfg_ready i_cfg_ticks_per_beat
//
// Parser takes a byte only when idle, so the next waits until this one is done;
// a final byte also goes through EOT and END. A note or rest is popped, runs
// a restoring divide, adds a halved step per dot, then emits; a 2-deep job queue
// lets the parser run ahead. Reset is synchronous, active low, and clears all
// control state. Either side may stall; the event register holds until taken.
module mml_text_to_note_events #(
    parameter int TIME_BITS = mml_pkg::TIME_BITS_DEF,
    parameter int MAX_TRACK = mml_pkg::MAX_TRACK_DEF,
    parameter int MAX_DOTS  = mml_pkg::MAX_DOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_char_code,
    input  logic        i_end_of_text,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_event_kind,
    output logic [31:0] o_event_time,
    output logic [3:0]  o_channel,
    output logic [6:0]  o_key,
    output logic [8:0]  o_value,
    output logic        o_error_seen,
    output logic        o_last_of_run,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_ticks_per_beat
);

    logic          w_push;
    mml_pkg::t_job w_job_in;
    logic          w_q_ready;
    logic          w_q_valid;
    mml_pkg::t_job w_job_out;
    logic          w_pop;

    assign o_cfg_ready = 1'b1;

    mml_front #(
        .MAX_TRACK (MAX_TRACK),
        .MAX_DOTS  (MAX_DOTS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_char_code   (i_char_code),
        .i_end_of_text (i_end_of_text),
        .o_push        (w_push),
        .o_job         (w_job_in),
        .i_q_ready     (w_q_ready)
    );

    mml_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job_in),
        .o_ready (w_q_ready),
        .o_valid (w_q_valid),
        .o_job   (w_job_out),
        .i_pop   (w_pop)
    );

    mml_back #(
        .TIME_BITS (TIME_BITS)
    ) u_back (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_valid          (i_cfg_valid),
        .i_cfg_ticks_per_beat (i_cfg_ticks_per_beat),
        .i_q_valid            (w_q_valid),
        .i_job                (w_job_out),
        .o_pop                (w_pop),
        .o_valid              (o_valid),
        .i_ready              (i_ready),
        .o_event_kind         (o_event_kind),
        .o_event_time         (o_event_time),
        .o_channel            (o_channel),
        .o_key                (o_key),
        .o_value              (o_value),
        .o_error_seen         (o_error_seen),
        .o_last_of_run        (o_last_of_run)
    );

endmodule

// ----- rtl/mml_queue.sv -----
module mml_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  mml_pkg::t_job i_job,
    output logic          o_ready,
    output logic          o_valid,
    output mml_pkg::t_job o_job,
    input  logic          i_pop
);

    mml_pkg::t_job r_mem [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;
    logic          w_push;
    logic          w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_mem[r_rp];
    assign w_push  = i_push && o_ready;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wp] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

endmodule

// ----- rtl/mml_front.sv -----
module mml_front #(
    parameter int MAX_TRACK = mml_pkg::MAX_TRACK_DEF,
    parameter int MAX_DOTS  = mml_pkg::MAX_DOTS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [7:0]    i_char_code,
    input  logic          i_end_of_text,
    output logic          o_push,
    output mml_pkg::t_job o_job,
    input  logic          i_q_ready
);

    mml_pkg::t_fstate r_state, n_state;
    mml_pkg::t_cmd    r_cmd, n_cmd;
    logic [7:0]  r_char;
    logic        r_eot;
    logic [2:0]  r_oct, n_oct;
    logic [7:0]  r_deflen, n_deflen;
    logic [6:0]  r_vol, n_vol;
    logic [8:0]  r_tempo, n_tempo;
    logic [3:0]  r_track, n_track;
    logic [15:0] r_acc, n_acc;
    logic        r_neg, n_neg;
    logic [6:0]  r_pitch, n_pitch;
    logic [3:0]  r_dots, n_dots;
    logic        r_comment, n_comment;
    logic        r_err, n_err;
    logic [1:0]  r_n1, n_n1;

    logic        w_stall;
    logic        w_eot_push;
    logic        w_eot_fit;
    logic [7:0]  w_lc;
    logic [4:0]  w_semi;
    logic        w_dig;
    logic [3:0]  w_dots_inc;

    logic          ab_ok;
    mml_pkg::t_cmd ab_cmd;
    logic [15:0]   ab_acc;
    logic          ab_neg;
    logic [6:0]    ab_pitch;
    logic [3:0]    ab_dots;

    logic [1:0]    fl_cnt;
    mml_pkg::t_job fl_job;
    logic [7:0]    fl_deflen;
    logic [2:0]    fl_oct;
    logic [6:0]    fl_vol;
    logic [8:0]    fl_tempo;
    logic [15:0]   w_c255, w_c127, w_c7, w_c500;

    mml_pkg::t_cmd st_cmd;
    logic          st_open;
    logic          st_note;
    logic [2:0]    st_oct;
    logic [3:0]    st_track;
    logic          st_comment;
    logic          st_err;
    logic [6:0]    st_pitch;

    assign o_ready    = (r_state == mml_pkg::F_IDLE);
    assign w_lc       = mml_pkg::to_lower(r_char);
    assign w_semi     = mml_pkg::semitone(w_lc);
    assign w_dig      = (r_char >= "0") && (r_char <= "9");
    assign w_dots_inc = (r_dots < 4'(MAX_DOTS)) ? r_dots + 4'd1 : r_dots;

    assign w_c255 = mml_pkg::clamp_num(r_acc, r_neg, 16'd255);
    assign w_c127 = mml_pkg::clamp_num(r_acc, r_neg, 16'd127);
    assign w_c7   = mml_pkg::clamp_num(r_acc, r_neg, 16'd7);
    assign w_c500 = mml_pkg::clamp_num(r_acc, r_neg, 16'd500);

    // absorb into pending command
    always_comb begin
        ab_ok    = 1'b0;
        ab_cmd   = r_cmd;
        ab_acc   = r_acc;
        ab_neg   = r_neg;
        ab_pitch = r_pitch;
        ab_dots  = r_dots;
        unique case (r_cmd)
            mml_pkg::CMD_LEN, mml_pkg::CMD_OCT, mml_pkg::CMD_PROG,
            mml_pkg::CMD_VOL, mml_pkg::CMD_TEMPO: begin
                if (w_dig) begin
                    ab_ok  = 1'b1;
                    ab_acc = mml_pkg::digit_in(r_acc, r_char);
                end else if (r_char == "-") begin
                    ab_ok  = 1'b1;
                    ab_neg = 1'b1;
                end
            end
            mml_pkg::CMD_NOTE_ACC: begin
                if (r_char == "-") begin
                    ab_ok    = 1'b1;
                    ab_pitch = r_pitch + 7'd127;
                    ab_cmd   = mml_pkg::CMD_NOTE_NUM;
                end else if (r_char == "+" || r_char == "#") begin
                    ab_ok    = 1'b1;
                    ab_pitch = r_pitch + 7'd1;
                    ab_cmd   = mml_pkg::CMD_NOTE_NUM;
                end else if (w_dig) begin
                    ab_ok  = 1'b1;
                    ab_acc = mml_pkg::digit_in(r_acc, r_char);
                    ab_cmd = mml_pkg::CMD_NOTE_NUM;
                end else if (r_char == ".") begin
                    ab_ok   = 1'b1;
                    ab_dots = w_dots_inc;
                    ab_cmd  = mml_pkg::CMD_NOTE_DOT;
                end
            end
            mml_pkg::CMD_NOTE_NUM, mml_pkg::CMD_REST_NUM: begin
                if (w_dig) begin
                    ab_ok  = 1'b1;
                    ab_acc = mml_pkg::digit_in(r_acc, r_char);
                end else if (r_char == "-") begin
                    ab_ok = 1'b1;
                end else if (r_char == ".") begin
                    ab_ok   = 1'b1;
                    ab_dots = w_dots_inc;
                    ab_cmd  = (r_cmd == mml_pkg::CMD_NOTE_NUM) ? mml_pkg::CMD_NOTE_DOT
                                                               : mml_pkg::CMD_REST_DOT;
                end
            end
            mml_pkg::CMD_NOTE_DOT, mml_pkg::CMD_REST_DOT: begin
                if (r_char == ".") begin
                    ab_ok   = 1'b1;
                    ab_dots = w_dots_inc;
                end
            end
            default: ab_ok = 1'b0;
        endcase
    end

    // complete pending command
    always_comb begin
        fl_cnt        = 2'd0;
        fl_deflen     = r_deflen;
        fl_oct        = r_oct;
        fl_vol        = r_vol;
        fl_tempo      = r_tempo;
        fl_job        = '0;
        fl_job.op     = mml_pkg::EV_END;
        fl_job.chan   = r_track;
        fl_job.den    = (r_acc != 16'd0) ? r_acc : {8'b0, r_deflen};
        fl_job.dots   = r_dots;
        unique case (r_cmd)
            mml_pkg::CMD_LEN: fl_deflen = w_c255[7:0];
            mml_pkg::CMD_OCT: fl_oct    = w_c7[2:0];
            mml_pkg::CMD_VOL: fl_vol    = w_c127[6:0];
            mml_pkg::CMD_PROG: begin
                fl_cnt       = 2'd1;
                fl_job.op    = mml_pkg::EV_PROG;
                fl_job.value = {2'b0, w_c127[6:0]};
            end
            mml_pkg::CMD_TEMPO: begin
                fl_cnt       = 2'd1;
                fl_tempo     = w_c500[8:0];
                fl_job.op    = mml_pkg::EV_TEMPO;
                fl_job.value = w_c500[8:0];
                fl_job.chan  = 4'd0;
            end
            mml_pkg::CMD_NOTE_ACC, mml_pkg::CMD_NOTE_NUM, mml_pkg::CMD_NOTE_DOT: begin
                fl_cnt       = 2'd2;
                fl_job.op    = mml_pkg::EV_NOTE_ON;
                fl_job.key   = r_pitch;
                fl_job.value = {2'b0, r_vol};
            end
            mml_pkg::CMD_REST_NUM, mml_pkg::CMD_REST_DOT: begin
                fl_cnt    = 2'd1;
                fl_job.op = mml_pkg::EV_REST;
            end
            default: fl_cnt = 2'd0;
        endcase
    end

    // open a command or act on an immediate one
    always_comb begin
        st_cmd     = mml_pkg::CMD_NONE;
        st_open    = 1'b0;
        st_note    = 1'b0;
        st_oct     = fl_oct;
        st_track   = r_track;
        st_comment = r_comment;
        st_err     = r_err;
        st_pitch   = 7'(({4'b0, fl_oct} << 3) + ({4'b0, fl_oct} << 2) + {3'b0, w_semi[3:0]});
        if (w_semi[4]) begin
            st_cmd  = mml_pkg::CMD_NOTE_ACC;
            st_open = 1'b1;
            st_note = 1'b1;
        end else begin
            unique case (w_lc)
                "l": begin st_cmd = mml_pkg::CMD_LEN;      st_open = 1'b1; end
                "o": begin st_cmd = mml_pkg::CMD_OCT;      st_open = 1'b1; end
                "@": begin st_cmd = mml_pkg::CMD_PROG;     st_open = 1'b1; end
                "v": begin st_cmd = mml_pkg::CMD_VOL;      st_open = 1'b1; end
                "t": begin st_cmd = mml_pkg::CMD_TEMPO;    st_open = 1'b1; end
                "r", "p": begin st_cmd = mml_pkg::CMD_REST_NUM; st_open = 1'b1; end
                "<": if (fl_oct != 3'd7) st_oct = fl_oct + 3'd1;
                ">": if (fl_oct != 3'd0) st_oct = fl_oct - 3'd1;
                "/": if (r_track < 4'(MAX_TRACK)) st_track = r_track + 4'd1;
                "#": st_comment = 1'b1;
                "&", ",", "[", "]", " ", mml_pkg::CH_TAB, mml_pkg::CH_LF, mml_pkg::CH_CR: ;
                default: st_err = 1'b1;
            endcase
        end
    end

    // words that do not fit go out quiet, so time still advances
    assign w_eot_push = (fl_cnt != 2'd0);
    assign w_eot_fit  = (({1'b0, r_n1} + {1'b0, fl_cnt}) <= 3'd2);

    always_comb begin
        unique case (r_state)
            mml_pkg::F_MAIN: w_stall = !r_comment && !ab_ok && (fl_cnt != 2'd0) && !i_q_ready;
            mml_pkg::F_EOT:  w_stall = w_eot_push && !i_q_ready;
            mml_pkg::F_END:  w_stall = !i_q_ready;
            default:         w_stall = 1'b0;
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mml_pkg::F_IDLE: if (i_valid) n_state = mml_pkg::F_MAIN;
            mml_pkg::F_MAIN: if (!w_stall) n_state = r_eot ? mml_pkg::F_EOT : mml_pkg::F_IDLE;
            mml_pkg::F_EOT:  if (!w_stall) n_state = mml_pkg::F_END;
            mml_pkg::F_END:  if (!w_stall) n_state = mml_pkg::F_IDLE;
            default:         n_state = mml_pkg::F_IDLE;
        endcase
    end

    always_comb begin
        n_cmd     = r_cmd;
        n_oct     = r_oct;
        n_deflen  = r_deflen;
        n_vol     = r_vol;
        n_tempo   = r_tempo;
        n_track   = r_track;
        n_acc     = r_acc;
        n_neg     = r_neg;
        n_pitch   = r_pitch;
        n_dots    = r_dots;
        n_comment = r_comment;
        n_err     = r_err;
        n_n1      = r_n1;
        o_push    = 1'b0;
        o_job     = fl_job;
        unique case (r_state)
            mml_pkg::F_MAIN: if (!w_stall) begin
                n_n1 = 2'd0;
                if (r_comment) begin
                    if (r_char == mml_pkg::CH_LF) n_comment = 1'b0;
                end else if (ab_ok) begin
                    n_cmd   = ab_cmd;
                    n_acc   = ab_acc;
                    n_neg   = ab_neg;
                    n_pitch = ab_pitch;
                    n_dots  = ab_dots;
                end else begin
                    o_push     = (fl_cnt != 2'd0);
                    o_job.last = !r_eot;
                    o_job.err  = st_err;
                    n_n1       = fl_cnt;
                    n_deflen   = fl_deflen;
                    n_vol      = fl_vol;
                    n_tempo    = fl_tempo;
                    n_oct      = st_oct;
                    n_track    = st_track;
                    n_comment  = st_comment;
                    n_err      = st_err;
                    n_cmd      = st_cmd;
                    if (st_open) begin
                        n_acc  = 16'd0;
                        n_neg  = 1'b0;
                        n_dots = 4'd0;
                    end
                    if (st_note) n_pitch = st_pitch;
                end
            end
            mml_pkg::F_EOT: if (!w_stall) begin
                o_push      = w_eot_push;
                o_job.last  = 1'b0;
                o_job.err   = r_err;
                o_job.quiet = !w_eot_fit;
                n_deflen    = fl_deflen;
                n_oct       = fl_oct;
                n_vol       = fl_vol;
                n_tempo     = fl_tempo;
                n_cmd       = mml_pkg::CMD_NONE;
            end
            mml_pkg::F_END: begin
                o_push     = !w_stall;
                o_job      = '0;
                o_job.op   = mml_pkg::EV_END;
                o_job.chan = r_track;
                o_job.err  = r_err;
                o_job.last = 1'b1;
            end
            default: o_push = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_char <= i_char_code;
            r_eot  <= i_end_of_text;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= mml_pkg::F_IDLE;
            r_cmd     <= mml_pkg::CMD_NONE;
            r_oct     <= mml_pkg::OCT_RESET;
            r_deflen  <= mml_pkg::LEN_RESET;
            r_vol     <= mml_pkg::VOL_RESET;
            r_tempo   <= mml_pkg::TEMPO_RESET;
            r_track   <= 4'd0;
            r_acc     <= 16'd0;
            r_neg     <= 1'b0;
            r_pitch   <= 7'd0;
            r_dots    <= 4'd0;
            r_comment <= 1'b0;
            r_err     <= 1'b0;
            r_n1      <= 2'd0;
        end else begin
            r_state   <= n_state;
            r_cmd     <= n_cmd;
            r_oct     <= n_oct;
            r_deflen  <= n_deflen;
            r_vol     <= n_vol;
            r_tempo   <= n_tempo;
            r_track   <= n_track;
            r_acc     <= n_acc;
            r_neg     <= n_neg;
            r_pitch   <= n_pitch;
            r_dots    <= n_dots;
            r_comment <= n_comment;
            r_err     <= n_err;
            r_n1      <= n_n1;
        end
    end

endmodule

// ----- rtl/mml_back.sv -----
module mml_back #(
    parameter int TIME_BITS = mml_pkg::TIME_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_valid,
    input  logic [15:0]   i_cfg_ticks_per_beat,
    input  logic          i_q_valid,
    input  mml_pkg::t_job i_job,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [2:0]    o_event_kind,
    output logic [31:0]   o_event_time,
    output logic [3:0]    o_channel,
    output logic [6:0]    o_key,
    output logic [8:0]    o_value,
    output logic          o_error_seen,
    output logic          o_last_of_run
);

    localparam int DB = mml_pkg::DIV_BITS;
    localparam int UB = mml_pkg::DUR_BITS;

    mml_pkg::t_bstate r_state, n_state;
    mml_pkg::t_job    r_job;
    logic [15:0]      r_tpb;
    logic [15:0]      r_rem;
    logic [DB-1:0]    r_quo;
    logic [mml_pkg::CNT_BITS-1:0] r_cnt;
    logic [DB-1:0]    r_add;
    logic [UB-1:0]    r_dur;
    logic [3:0]       r_dcnt;
    logic [TIME_BITS-1:0] r_song;

    logic             r_ov;
    mml_pkg::t_event  r_kind;
    logic [TIME_BITS-1:0] r_time;
    logic [3:0]       r_chan;
    logic [6:0]       r_key;
    logic [8:0]       r_value;
    logic             r_err;
    logic             r_last;

    logic             w_timed;
    logic             w_load;
    logic             w_emit;
    logic [16:0]      w_rem_sh;
    logic             w_qbit;
    logic [16:0]      w_rem_sub;
    logic [TIME_BITS+UB-1:0] w_sum_ext;
    logic [TIME_BITS-1:0]    w_sum;
    logic [TIME_BITS+31:0]   w_time_ext;

    assign w_timed = (i_job.op == mml_pkg::EV_NOTE_ON) || (i_job.op == mml_pkg::EV_REST);
    assign w_load  = !r_ov || i_ready;
    assign w_rem_sh  = {r_rem, r_quo[DB-1]};
    assign w_qbit    = (w_rem_sh >= {1'b0, r_job.den});
    assign w_rem_sub = w_rem_sh - {1'b0, r_job.den};
    assign w_sum_ext = {{UB{1'b0}}, r_song} + {{TIME_BITS{1'b0}}, r_dur};
    assign w_sum     = w_sum_ext[TIME_BITS-1:0];
    assign w_time_ext = {32'b0, r_time};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mml_pkg::B_IDLE: if (i_q_valid) begin
                if (w_timed && i_job.den != 16'd0) n_state = mml_pkg::B_DIV;
                else n_state = mml_pkg::B_EMIT;
            end
            mml_pkg::B_DIV:  if (r_cnt == '0) n_state = mml_pkg::B_DOT;
            mml_pkg::B_DOT:  if (r_dcnt == 4'd0) n_state = mml_pkg::B_EMIT;
            mml_pkg::B_EMIT: if (r_job.quiet) begin
                n_state = mml_pkg::B_IDLE;
            end else if (w_load) begin
                n_state = (r_job.op == mml_pkg::EV_NOTE_ON) ? mml_pkg::B_EMIT2
                                                            : mml_pkg::B_IDLE;
            end
            mml_pkg::B_EMIT2: if (w_load) n_state = mml_pkg::B_IDLE;
            default: n_state = mml_pkg::B_IDLE;
        endcase
    end

    always_comb begin
        o_pop  = (r_state == mml_pkg::B_IDLE) && i_q_valid;
        w_emit = ((r_state == mml_pkg::B_EMIT) || (r_state == mml_pkg::B_EMIT2)) && w_load &&
                 !r_job.quiet;
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
            r_rem <= 16'd0;
            r_quo <= {r_tpb, 2'b00};
            r_cnt <= mml_pkg::CNT_BITS'(DB);
            r_dur <= '0;
        end else if (r_state == mml_pkg::B_DIV) begin
            if (r_cnt == '0) begin
                r_add  <= r_quo;
                r_dur  <= {1'b0, r_quo};
                r_dcnt <= r_job.dots;
            end else begin
                r_rem <= w_qbit ? w_rem_sub[15:0] : w_rem_sh[15:0];
                r_quo <= {r_quo[DB-2:0], w_qbit};
                r_cnt <= r_cnt - 1'b1;
            end
        end else if (r_state == mml_pkg::B_DOT && r_dcnt != 4'd0) begin
            r_add  <= r_add >> 1;
            r_dur  <= r_dur + {2'b0, r_add[DB-1:1]};
            r_dcnt <= r_dcnt - 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_chan <= r_job.chan;
            r_err  <= r_job.err;
            if (r_state == mml_pkg::B_EMIT2) begin
                r_kind  <= mml_pkg::EV_NOTE_OFF;
                r_time  <= r_song;
                r_key   <= r_job.key;
                r_value <= 9'd0;
                r_last  <= r_job.last;
            end else begin
                r_kind  <= r_job.op;
                r_time  <= (r_job.op == mml_pkg::EV_REST) ? w_sum : r_song;
                r_key   <= r_job.key;
                r_value <= r_job.value;
                r_last  <= (r_job.op == mml_pkg::EV_NOTE_ON) ? 1'b0 : r_job.last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mml_pkg::B_IDLE;
            r_tpb   <= mml_pkg::TPB_RESET;
            r_song  <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) r_tpb <= i_cfg_ticks_per_beat;
            if ((w_emit || r_job.quiet) && r_state == mml_pkg::B_EMIT &&
                (r_job.op == mml_pkg::EV_NOTE_ON || r_job.op == mml_pkg::EV_REST)) begin
                r_song <= w_sum;
            end
            if (w_emit) r_ov <= 1'b1;
            else if (i_ready) r_ov <= 1'b0;
        end
    end

    assign o_valid       = r_ov;
    assign o_event_kind  = r_kind;
    assign o_event_time  = w_time_ext[31:0];
    assign o_channel     = r_chan;
    assign o_key         = r_key;
    assign o_value       = r_value;
    assign o_error_seen  = r_err;
    assign o_last_of_run = r_last;

endmodule

// ----- rtl/mml_checker.sv -----
module mml_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic [7:0]  i_char_code,
    input logic        i_end_of_text,
    input logic        o_valid,
    input logic        i_ready,
    input logic [2:0]  o_event_kind,
    input logic [31:0] o_event_time,
    input logic [3:0]  o_channel,
    input logic [6:0]  o_key,
    input logic [8:0]  o_value,
    input logic        o_error_seen,
    input logic        o_last_of_run,
    input logic        i_cfg_valid,
    input logic        o_cfg_ready,
    input logic [15:0] i_cfg_ticks_per_beat
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_event_time) && $stable(o_event_kind))
        else $error("event word changed while stalled");

    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_event_kind == mml_pkg::EV_END |-> o_last_of_run)
        else $error("end event not last of run");

    a_tempo_chan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_event_kind == mml_pkg::EV_TEMPO |-> o_channel == 4'd0 && o_key == 7'd0)
        else $error("tempo event carries channel or key");

    a_zero_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_event_kind == mml_pkg::EV_NOTE_OFF || o_event_kind == mml_pkg::EV_REST ||
                    o_event_kind == mml_pkg::EV_END) |-> o_value == 9'd0)
        else $error("nonzero value on valueless event");

    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && o_error_seen |=> !o_valid || o_error_seen)
        else $error("error flag cleared");

endmodule

bind mml_text_to_note_events mml_checker u_chk (.*);
